>>> hw/rtl/rrse_pkg.sv
// ----------------------------------------------------------------------------
// rrse_pkg: shared types and constants
// Table size, word layout, operation codes and sequencer states for the
// read range set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rrse_pkg;

    localparam int MAX_RANGES = 64;
    localparam int ADDR_W     = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int NUM_W      = 31;
    localparam int ENTRY_W    = 2 * NUM_W;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TRIM  = 2'd2,
        OP_MARK  = 2'd3
    } op_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MSTART,
        S_RD,
        S_EV,
        S_NRD,
        S_NEV,
        S_SH,
        S_SH_WR,
        S_RM,
        S_RM_WR,
        S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/read_range_set_engine_core.sv
// ----------------------------------------------------------------------------
// read_range_set_engine_core: read article range set
// Disjoint ranges held highest first in a single-port-write table, walked
// and shifted one entry at a time by a small sequencer.
//
//   channel | dir | handshake          | words
//   in      | in  | in_valid/in_ready  | kind, first_number, second_number
//   out     | out | out_valid/out_ready| was_read, top_high, range_count, overflow
//
// Clear and top-only load/trim finish without a walk. Walks read each entry
// in S_RD and test it in S_EV (registered table read); an insert or removal
// moves entries via S_SH/S_SH_WR or S_RM/S_RM_WR. Worst case is a mark that
// walks then shifts. One word in flight; in_ready is low while the sequencer
// runs. Reset empties the set at once, no clearing pass. A stalled result
// word holds in the output register; the next word may be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module read_range_set_engine_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              kind,
    input  wire logic [rrse_pkg::NUM_W-1:0] first_number,
    input  wire logic [rrse_pkg::NUM_W-1:0] second_number,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         was_read,
    output logic [rrse_pkg::NUM_W-1:0]   top_high,
    output logic [rrse_pkg::CNT_W-1:0]   range_count,
    output logic                         overflow
);
    import rrse_pkg::*;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);
    localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1);

    seq_state_t state_reg, state_next;
    op_kind_t   op_reg, op_next;
    logic [NUM_W-1:0] n_reg, n_next, b_reg, b_next;
    logic [CNT_W-1:0] idx_reg, idx_next, pos_reg, pos_next, cnt_reg, cnt_next;
    logic [NUM_W-1:0] top_lo_reg, top_lo_next, top_hi_reg, top_hi_next;
    logic [NUM_W-1:0] ins_lo_reg, ins_lo_next, ins_hi_reg, ins_hi_next;
    logic             phase_reg, phase_next;
    logic             was_reg, was_next, ovf_reg, ovf_next;
    logic             ov_reg, ov_next, owas_reg, owas_next, oovf_reg, oovf_next;
    logic [NUM_W-1:0] otop_reg, otop_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;

    logic [ENTRY_W-1:0] mem [MAX_RANGES];
    logic [ENTRY_W-1:0] rdata;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic [NUM_W-1:0] rd_lo, rd_hi, in_lo, in_hi, floor_hi;
    logic [NUM_W:0]   rd_h1, top_h1;
    logic             full, accept, out_free, walk_end;
    logic             ld_merge, tr_reset, ev_trim_hit;
    logic             m_above, m_ext_hi, m_inside, m_ext_lo, m_has_next;
    logic             mk_read_stop, mk_top_new;
    logic [CNT_W-1:0] idx_inc, idx_dec, pos_inc;

    assign rd_lo    = rdata[ENTRY_W-1:NUM_W];
    assign rd_hi    = rdata[NUM_W-1:0];
    assign rd_h1    = {1'b0, rd_hi} + (NUM_W+1)'(1);
    assign top_h1   = {1'b0, top_hi_reg} + (NUM_W+1)'(1);
    assign full     = (cnt_reg == CNT_MAX);
    assign accept   = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;
    assign walk_end = (idx_reg == cnt_reg);
    assign idx_inc  = idx_reg + CNT_ONE;
    assign idx_dec  = idx_reg - CNT_ONE;
    assign pos_inc  = pos_reg + CNT_ONE;
    assign in_lo    = (second_number < first_number) ? second_number : first_number;
    assign in_hi    = (second_number < first_number) ? first_number : second_number;
    assign floor_hi = (n_reg > NUM_ONE) ? (n_reg - NUM_ONE) : NUM_ONE;

    assign ld_merge    = (cnt_reg != '0) && ({1'b0, n_reg} <= top_h1);
    assign tr_reset    = (cnt_reg == '0) || (top_hi_reg > b_reg);
    assign mk_top_new  = (cnt_reg == '0) || ({1'b0, n_reg} > top_h1);
    assign ev_trim_hit = (rd_lo < n_reg);
    assign mk_read_stop = (n_reg > rd_hi) || (n_reg >= rd_lo);
    assign m_above    = ({1'b0, n_reg} > rd_h1);
    assign m_ext_hi   = ({1'b0, n_reg} == rd_h1);
    assign m_inside   = (n_reg >= rd_lo) && (n_reg <= rd_hi);
    assign m_ext_lo   = (rd_lo != '0) && (n_reg == rd_lo - NUM_ONE);
    assign m_has_next = (idx_inc < cnt_reg);

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign was_read    = owas_reg;
    assign top_high    = otop_reg;
    assign range_count = ocnt_reg;
    assign overflow    = oovf_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_START;
            S_START:
            begin
                case (op_reg)
                    OP_CLEAR: state_next = S_DONE;
                    OP_LOAD:  state_next = (ld_merge || full) ? S_DONE : S_SH;
                    OP_TRIM:  state_next = tr_reset ? S_DONE : S_RD;
                    default:  state_next = S_RD;
                endcase
            end
            S_MSTART: state_next = mk_top_new ? (full ? S_DONE : S_SH) : S_RD;
            S_RD:
            begin
                if (!walk_end)
                begin
                    state_next = S_EV;
                end
                else if (op_reg == OP_MARK && !phase_reg)
                begin
                    state_next = S_MSTART;
                end
                else if (op_reg == OP_MARK)
                begin
                    state_next = full ? S_DONE : S_SH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EV:
            begin
                if (op_reg == OP_TRIM)
                begin
                    state_next = ev_trim_hit ? S_DONE : S_RD;
                end
                else if (!phase_reg)
                begin
                    state_next = mk_read_stop ? S_MSTART : S_RD;
                end
                else if (m_above)
                begin
                    state_next = full ? S_DONE : S_SH;
                end
                else if (m_ext_hi || m_inside)
                begin
                    state_next = S_DONE;
                end
                else if (m_ext_lo)
                begin
                    state_next = m_has_next ? S_NRD : S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_NRD:    state_next = S_NEV;
            S_NEV:    state_next = ({1'b0, n_reg} == rd_h1) ? S_RM : S_DONE;
            S_SH:     state_next = (idx_reg == pos_reg) ? S_DONE : S_SH_WR;
            S_SH_WR:  state_next = S_SH;
            S_RM:     state_next = (idx_inc >= cnt_reg) ? S_DONE : S_RM_WR;
            S_RM_WR:  state_next = S_RM;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        n_next      = n_reg;
        b_next      = b_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        ins_lo_next = ins_lo_reg;
        ins_hi_next = ins_hi_reg;
        phase_next  = phase_reg;
        was_next    = was_reg;
        ovf_next    = ovf_reg;
        top_lo_next = top_lo_reg;
        top_hi_next = top_hi_reg;
        ov_next     = ov_reg;
        owas_next   = owas_reg;
        otop_next   = otop_reg;
        ocnt_next   = ocnt_reg;
        oovf_next   = oovf_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_kind_t'(kind);
                    phase_next = 1'b0;
                    was_next   = 1'b0;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    if (op_kind_t'(kind) == OP_LOAD)
                    begin
                        n_next = in_lo;
                        b_next = in_hi;
                    end
                    else
                    begin
                        n_next = first_number;
                        b_next = second_number;
                    end
                end
            end
            S_START:
            begin
                case (op_reg)
                    OP_CLEAR: cnt_next = '0;
                    OP_LOAD:
                    begin
                        if (ld_merge)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {(n_reg < top_lo_reg) ? n_reg : top_lo_reg,
                                         (b_reg > top_hi_reg) ? b_reg : top_hi_reg};
                        end
                        else if (full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ins_lo_next = n_reg;
                            ins_hi_next = b_reg;
                            pos_next    = '0;
                            idx_next    = cnt_reg;
                        end
                    end
                    OP_TRIM:
                    begin
                        if (tr_reset)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {NUM_ONE, floor_hi};
                            cnt_next  = CNT_ONE;
                        end
                    end
                    default: ;
                endcase
            end
            S_MSTART:
            begin
                phase_next = 1'b1;
                if (mk_top_new)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ins_lo_next = n_reg;
                        ins_hi_next = n_reg;
                        pos_next    = '0;
                        idx_next    = cnt_reg;
                    end
                end
                else
                begin
                    idx_next = '0;
                end
            end
            S_RD:
            begin
                mem_raddr = idx_reg[ADDR_W-1:0];
                if (walk_end && op_reg == OP_MARK && phase_reg)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ins_lo_next = n_reg;
                        ins_hi_next = n_reg;
                        pos_next    = cnt_reg;
                    end
                end
            end
            S_EV:
            begin
                if (op_reg == OP_TRIM)
                begin
                    if (ev_trim_hit)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg[ADDR_W-1:0];
                        mem_wdata = {NUM_ONE, (rd_hi < n_reg) ? (n_reg - NUM_ONE) : rd_hi};
                        cnt_next  = idx_inc;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                else if (!phase_reg)
                begin
                    if (mk_read_stop)
                    begin
                        was_next = (n_reg <= rd_hi);
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                else if (m_above)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ins_lo_next = n_reg;
                        ins_hi_next = n_reg;
                        pos_next    = idx_reg;
                        idx_next    = cnt_reg;
                    end
                end
                else if (m_ext_hi)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[ADDR_W-1:0];
                    mem_wdata = {rd_lo, n_reg};
                end
                else if (m_inside)
                begin
                    idx_next = idx_reg;
                end
                else if (m_ext_lo)
                begin
                    pos_next    = idx_reg;
                    ins_hi_next = rd_hi;
                    if (!m_has_next)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg[ADDR_W-1:0];
                        mem_wdata = {n_reg, rd_hi};
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_NRD:
            begin
                mem_raddr = pos_inc[ADDR_W-1:0];
            end
            S_NEV:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[ADDR_W-1:0];
                if ({1'b0, n_reg} == rd_h1)
                begin
                    mem_wdata = {rd_lo, ins_hi_reg};
                    idx_next  = pos_inc;
                end
                else
                begin
                    mem_wdata = {n_reg, ins_hi_reg};
                end
            end
            S_SH:
            begin
                if (idx_reg == pos_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[ADDR_W-1:0];
                    mem_wdata = {ins_lo_reg, ins_hi_reg};
                    cnt_next  = cnt_reg + CNT_ONE;
                end
                else
                begin
                    mem_raddr = idx_dec[ADDR_W-1:0];
                end
            end
            S_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = rdata;
                idx_next  = idx_dec;
            end
            S_RM:
            begin
                if (idx_inc >= cnt_reg)
                begin
                    cnt_next = cnt_reg - CNT_ONE;
                end
                else
                begin
                    mem_raddr = idx_inc[ADDR_W-1:0];
                end
            end
            S_RM_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = rdata;
                idx_next  = idx_inc;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    owas_next = was_reg;
                    otop_next = (cnt_reg != '0) ? top_hi_reg : '0;
                    ocnt_next = cnt_reg;
                    oovf_next = ovf_reg;
                end
            end
            default: ;
        endcase

        if (mem_we && mem_waddr == '0)
        begin
            top_lo_next = mem_wdata[ENTRY_W-1:NUM_W];
            top_hi_next = mem_wdata[NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        n_reg      <= n_next;
        b_reg      <= b_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        ins_lo_reg <= ins_lo_next;
        ins_hi_reg <= ins_hi_next;
        phase_reg  <= phase_next;
        was_reg    <= was_next;
        ovf_reg    <= ovf_next;
        top_lo_reg <= top_lo_next;
        top_hi_reg <= top_hi_next;
        owas_reg   <= owas_next;
        otop_reg   <= otop_next;
        ocnt_reg   <= ocnt_next;
        oovf_reg   <= oovf_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/rrse_checker.sv
// ----------------------------------------------------------------------------
// rrse_checker: port-level checks
// Watches the result channel of the read range set engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rrse_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         was_read,
    input wire logic [rrse_pkg::NUM_W-1:0]   top_high,
    input wire logic [rrse_pkg::CNT_W-1:0]   range_count,
    input wire logic                         overflow
);
    import rrse_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(top_high)
            && $stable(range_count) && $stable(was_read) && $stable(overflow))
        else $error("result word changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> range_count <= CNT_W'(MAX_RANGES))
        else $error("range count beyond table size");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_count == '0 |-> top_high == '0 && !was_read)
        else $error("empty set reports a top or a read number");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> range_count == CNT_W'(MAX_RANGES))
        else $error("overflow with room left");

endmodule

bind read_range_set_engine_core rrse_checker u_rrse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .was_read    (was_read),
    .top_high    (top_high),
    .range_count (range_count),
    .overflow    (overflow)
);

`default_nettype wire
